// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, also evaluated while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tea_pkg.sv =====
// Types, constants and helpers shared by the cipher core, its stages and its checker.
package tea_pkg;

	localparam int unsigned ROUNDS = 32;
	localparam int unsigned STAGES = 2 * ROUNDS;
	localparam logic [31:0] DELTA  = 32'h9E3779B9;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_KEY_WORD0 = 3'd0,
		REG_KEY_WORD1 = 3'd1,
		REG_KEY_WORD2 = 3'd2,
		REG_KEY_WORD3 = 3'd3,
		REG_DECRYPT   = 3'd4
	} tea_reg_t;

	typedef struct packed {
		logic [31:0] block_left;
		logic [31:0] block_right;
	} tea_in_t;

	typedef struct packed {
		logic [31:0] result_left;
		logic [31:0] result_right;
	} tea_out_t;

	typedef struct packed {
		logic [31:0] v0;
		logic [31:0] v1;
	} tea_blk_t;

	// Per-stage controls for one half round.
	typedef struct packed {
		logic [31:0] sum;
		logic [31:0] key_a;
		logic [31:0] key_b;
		logic        upd_left;
		logic        sub;
	} tea_rnd_t;

	// Running sum after n additions of delta, modulo 2^32.
	function automatic logic [31:0] tea_sum(input int unsigned n);
		logic [63:0] p;
		p = 64'(DELTA) * 64'(n);
		return p[31:0];
	endfunction

endpackage

// ===== src/tea_block_cipher_core.sv =====
// Pipelined 64-bit block cipher core, one half round per stage.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------
//  in      | in  | in_valid / in_stall  | in_data  (block_left, right)
//  out     | out | out_valid / out_stall| out_data (result_left, right)
//  cfg     | in  | cfg_we               | cfg_addr, cfg_data
//
// One block enters per cycle while in_stall is low; each block passes through 2*ROUNDS
// half-round stages (64) and then the output register.
// Reset clears all valid bits and the key and mode registers to zero.
// A two-entry output buffer keeps the pipe moving while an entry is free;
// in_stall rises only once both entries hold a block and drops as the first is taken.
module tea_block_cipher_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tea_pkg::tea_in_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output tea_pkg::tea_out_t                out_data,
	input  logic                             cfg_we,
	input  logic [tea_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [tea_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tea_pkg::*;

	logic [31:0] key0_q;
	logic [31:0] key1_q;
	logic [31:0] key2_q;
	logic [31:0] key3_q;
	logic        decrypt_q;

	logic        advance;
	logic        push;
	logic        pop;
	logic        out_valid_q;
	tea_blk_t    out_blk_q;
	logic        skid_valid_q;
	tea_blk_t    skid_blk_q;

	logic     vld [STAGES+1];
	tea_blk_t blk [STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q    <= '0;
			key1_q    <= '0;
			key2_q    <= '0;
			key3_q    <= '0;
			decrypt_q <= 1'b0;
		end else if (cfg_we) begin
			case (tea_reg_t'(cfg_addr))
				REG_KEY_WORD0: key0_q    <= cfg_data[31:0];
				REG_KEY_WORD1: key1_q    <= cfg_data[31:0];
				REG_KEY_WORD2: key2_q    <= cfg_data[31:0];
				REG_KEY_WORD3: key3_q    <= cfg_data[31:0];
				REG_DECRYPT:   decrypt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Whole pipe moves unless the output buffer is full.
	assign advance  = !skid_valid_q;
	assign in_stall = skid_valid_q;

	assign vld[0] = in_valid;
	assign blk[0] = '{v0: in_data.block_left, v1: in_data.block_right};

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		localparam int unsigned RND  = s / 2;
		localparam bit          EVEN = (s % 2) == 0;
		localparam logic [31:0] SUM_ENC = tea_sum(RND + 1);
		localparam logic [31:0] SUM_DEC = tea_sum(ROUNDS - RND);

		tea_rnd_t rnd;

		always_comb begin
			rnd.upd_left = EVEN ^ decrypt_q;
			rnd.sub      = decrypt_q;
			rnd.sum      = decrypt_q ? SUM_DEC : SUM_ENC;
			rnd.key_a    = rnd.upd_left ? key0_q : key2_q;
			rnd.key_b    = rnd.upd_left ? key1_q : key3_q;
		end

		tea_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.in_vld  (vld[s]),
			.in_blk  (blk[s]),
			.rnd     (rnd),
			.vld     (vld[s+1]),
			.blk     (blk[s+1])
		);
	end

	assign push = advance && vld[STAGES];
	assign pop  = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_valid_q) begin
			if (push && !pop) begin
				skid_valid_q <= 1'b1;
			end else if (pop && !push) begin
				out_valid_q <= 1'b0;
			end
		end else if (push) begin
			out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_blk_q <= skid_blk_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_blk_q <= blk[STAGES];
			end else begin
				out_blk_q <= blk[STAGES];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = '{result_left: out_blk_q.v0, result_right: out_blk_q.v1};

endmodule

// ===== src/tea_stage.sv =====
// One half round of the cipher with its pipeline register.
module tea_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             in_vld,
	input  tea_pkg::tea_blk_t in_blk,
	input  tea_pkg::tea_rnd_t rnd,
	output logic             vld,
	output tea_pkg::tea_blk_t blk
);
	import tea_pkg::*;

	logic [31:0] x;
	logic [31:0] y;
	logic [31:0] f;
	logic [31:0] ny;
	tea_blk_t    nxt;
	logic        valid_s;
	tea_blk_t    blk_s;

	always_comb begin
		x   = rnd.upd_left ? in_blk.v1 : in_blk.v0;
		y   = rnd.upd_left ? in_blk.v0 : in_blk.v1;
		f   = ((x << 4) + rnd.key_a) ^ (x + rnd.sum) ^ ((x >> 5) + rnd.key_b);
		ny  = rnd.sub ? (y - f) : (y + f);
		nxt = in_blk;
		if (rnd.upd_left) begin
			nxt.v0 = ny;
		end else begin
			nxt.v1 = ny;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (advance) begin
			valid_s <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_vld) begin
			blk_s <= nxt;
		end
	end

	assign vld = valid_s;
	assign blk = blk_s;

endmodule

// ===== src/tea_checker.sv =====
// Port-level checks on the cipher core and their binding.
`include "assert_macros.svh"

module tea_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input tea_pkg::tea_in_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input tea_pkg::tea_out_t out_data
);
	import tea_pkg::*;

	logic in_seen;

	assign in_seen = in_valid || (in_data != '0) || 1'b1;

	`ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result item changed or vanished")
	`ASSERT_ALWAYS(a_stall_needs_out, in_stall |-> out_valid && in_seen, "input stalled with no result item waiting")
	`ASSERT_CLK(a_stall_rise, $rose(in_stall) |-> $past(out_valid && out_stall), "input stall rose without a stalled result item")
	`ASSERT_CLK(a_stall_drain, in_stall && !out_stall |=> !in_stall, "input stall held after a result item was taken")

endmodule

bind tea_block_cipher_core tea_checker u_tea_checker (.*);

// ===== sim/tb_tea_block_cipher_core.sv =====
// Self-checking testbench for the pipelined TEA block cipher core.
module tb_tea_block_cipher_core;
	import tea_pkg::*;

	localparam int unsigned CIPHER_ROUNDS   = 32;
	localparam logic [31:0] TEA_DELTA       = 32'h9E3779B9;
	localparam int unsigned MAX_REPORTS     = 10;
	localparam int unsigned RANDOM_PHASES   = 12;
	localparam int unsigned ITEMS_PER_PHASE = 157;
	localparam int unsigned QUIET_PHASE     = 3;
	localparam int unsigned FLOOD_PHASE     = 6;
	localparam int unsigned LONG_HOLD       = 400;
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned TAIL_CYCLES     = 100;
	localparam int unsigned CYCLE_LIMIT     = 200_000;
	localparam tea_reg_t    KEY_REGS [4]    = '{REG_KEY_WORD0, REG_KEY_WORD1,
		REG_KEY_WORD2, REG_KEY_WORD3};

	// Predicts each ciphered block and matches it against the core's output.
	class cipher_scoreboard;
		logic [31:0] key [4];
		logic        decrypt_mode;
		tea_out_t    expected_blocks [$];
		int unsigned failures;
		int unsigned blocks_encrypted;
		int unsigned blocks_decrypted;
		int unsigned blocks_checked;

		function new();
			foreach (key[i]) key[i] = '0;
			decrypt_mode = 1'b0;
		endfunction

		function void write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_KEY_WORD0: key[0] = value;
				REG_KEY_WORD1: key[1] = value;
				REG_KEY_WORD2: key[2] = value;
				REG_KEY_WORD3: key[3] = value;
				REG_DECRYPT:   decrypt_mode = value[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] round_mix(logic [31:0] x, logic [31:0] sum,
			logic [31:0] a, logic [31:0] b);
			return ((x << 4) + a) ^ (x + sum) ^ ((x >> 5) + b);
		endfunction

		function tea_out_t cipher_block(tea_in_t blk);
			logic [31:0] v0;
			logic [31:0] v1;
			logic [31:0] sum;
			tea_out_t    res;
			v0 = blk.block_left;
			v1 = blk.block_right;
			if (!decrypt_mode) begin
				sum = '0;
				repeat (CIPHER_ROUNDS) begin
					sum += TEA_DELTA;
					v0 += round_mix(v1, sum, key[0], key[1]);
					v1 += round_mix(v0, sum, key[2], key[3]);
				end
			end else begin
				sum = TEA_DELTA * 32'(CIPHER_ROUNDS);
				repeat (CIPHER_ROUNDS) begin
					v1 -= round_mix(v0, sum, key[2], key[3]);
					v0 -= round_mix(v1, sum, key[0], key[1]);
					sum -= TEA_DELTA;
				end
			end
			res.result_left  = v0;
			res.result_right = v1;
			return res;
		endfunction

		function void note_block(tea_in_t blk);
			expected_blocks.insert(expected_blocks.size(), cipher_block(blk));
			if (decrypt_mode)
				blocks_decrypted++;
			else
				blocks_encrypted++;
		endfunction

		function void check_block(tea_out_t got);
			tea_out_t want;
			if (expected_blocks.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected result %h_%h with no block pending",
						got.result_left, got.result_right);
				return;
			end
			want = expected_blocks.pop_front();
			blocks_checked++;
			if (got.result_left !== want.result_left || got.result_right !== want.result_right) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("result %0d: left exp %h got %h, right exp %h got %h",
						blocks_checked, want.result_left, got.result_left,
						want.result_right, got.result_right);
			end
		endfunction

		function void close_out();
			if (expected_blocks.size() != 0) begin
				failures += expected_blocks.size();
				$display("%0d blocks never came out", expected_blocks.size());
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	tea_in_t               in_data;
	logic                  out_valid;
	logic                  out_stall;
	tea_out_t              out_data;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	cipher_scoreboard sb = new();
	bit          no_idle;
	bit          flood_mode;
	int unsigned settings_count;
	int unsigned cycle_count;

	tea_block_cipher_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tea_block_cipher_core verification failed");
		$finish;
	end

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		case ($urandom_range(9))
			0: w = '0;
			1: w = '1;
			2: w = 32'h1 << $urandom_range(31);
			3: w = ~(32'h1 << $urandom_range(31));
			default: w = $urandom();
		endcase
		return w;
	endfunction

	// Offer one block, idling at random first unless no_idle is set, and hold it until taken.
	task automatic send_block(input logic [31:0] left, input logic [31:0] right);
		tea_in_t blk;
		blk.block_left  = left;
		blk.block_right = right;
		while (!no_idle && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= blk;
		do @(posedge clk); while (in_stall);
		sb.note_block(blk);
	endtask

	task automatic write_step(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_register(idx, value);
	endtask

	// Load a full key and mode, with one write to an unused index in between.
	task automatic program_settings(input logic [127:0] keys, input logic [31:0] mode_word);
		logic [CFG_ADDR_W-1:0] stray;
		stray = CFG_ADDR_W'($urandom_range(2**CFG_ADDR_W - 1, REG_DECRYPT + 1));
		for (int i = 0; i < 4; i++)
			write_step(KEY_REGS[i], keys[127 - 32*i -: 32]);
		write_step(stray, $urandom());
		write_step(REG_DECRYPT, mode_word);
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	// Stop offering and wait until every pending block has come out.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (sb.expected_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: check taken items, stall at random, hold off once at length.
	initial begin
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_block(out_data);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (flood_mode && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_idle && $urandom_range(99) < 27;
			end
		end
	end

	initial begin
		logic [127:0] keys;
		logic [31:0]  mode_word;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		cfg_we   <= 1'b0;
		cfg_addr <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset key, encrypt: extreme halves.
		send_block('0, '0);
		send_block('1, '1);
		send_block('1, '0);
		send_block('0, '1);
		send_block(32'h8000_0000, 32'h0000_0001);
		drain_pipe();

		// All-ones key, decrypt with every high bit of the mode word set.
		program_settings('1, '1);
		send_block('0, '0);
		send_block('1, '1);
		send_block('1, '0);
		send_block('0, '1);
		send_block(32'h0000_0001, 32'h8000_0000);
		drain_pipe();

		// Random key; mode word high bits set but low bit clear, so encrypt.
		program_settings({random_word(), random_word(), random_word(), random_word()},
			32'hFFFF_FFFE);
		repeat (4) send_block(random_word(), random_word());
		drain_pipe();

		// Same key, decrypt.
		program_settings({sb.key[0], sb.key[1], sb.key[2], sb.key[3]}, 32'h0000_0001);
		repeat (2) send_block(random_word(), random_word());
		drain_pipe();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				keys = '0;
			else if (phase == 1)
				keys = '1;
			else
				keys = {random_word(), random_word(), random_word(), random_word()};
			mode_word    = $urandom();
			mode_word[0] = phase[0];
			program_settings(keys, mode_word);
			no_idle    = (phase == QUIET_PHASE) || (phase == FLOOD_PHASE);
			flood_mode = (phase == FLOOD_PHASE);
			repeat (ITEMS_PER_PHASE) send_block(random_word(), random_word());
			flood_mode = 1'b0;
			no_idle    = 1'b0;
			drain_pipe();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		$display("Ran %0d blocks through %0d key/mode settings: %0d encrypted, %0d decrypted.",
			sb.blocks_encrypted + sb.blocks_decrypted, settings_count + 1,
			sb.blocks_encrypted, sb.blocks_decrypted);
		$display("Checked %0d results; %0d failures.", sb.blocks_checked, sb.failures);
		if (sb.failures == 0)
			$display("tea_block_cipher_core verification clean");
		else
			$display("tea_block_cipher_core verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/tea_pkg.sv
src/tea_stage.sv
src/tea_block_cipher_core.sv
src/tea_checker.sv
sim/tb_tea_block_cipher_core.sv
